// File: design/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants for the bus frame receiver core.
// ----------------------------------------------------------------------------
package bfr_pkg;

   localparam int FRAME_CAPACITY = 1024;
   localparam int POS_W          = $clog2(FRAME_CAPACITY);

   localparam logic [7:0]  HEADER_BYTE   = 8'h7E;
   localparam logic [7:0]  ANY_TYPE      = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd700;

   // csr register indexes
   localparam logic CSR_TIMEOUT_TICKS  = 1'b0;
   localparam logic CSR_MY_DEVICE_TYPE = 1'b1;

   // input actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // result events
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_HEADER  = 3'd1;
   localparam logic [2:0] EV_LENGTH  = 3'd2;
   localparam logic [2:0] EV_BODY    = 3'd3;
   localparam logic [2:0] EV_GOOD    = 3'd4;
   localparam logic [2:0] EV_CSUM    = 3'd5;
   localparam logic [2:0] EV_TIMEOUT = 3'd6;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } bfr_req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  data_byte;
      logic [9:0]  byte_position;
      logic [15:0] frame_size;
      logic [7:0]  device_id;
      logic [7:0]  device_type;
      logic [7:0]  direction;
      logic [7:0]  command;
      logic        for_this_node;
   } bfr_rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  my_device_type;
   } bfr_cfg_type;

endpackage

// File: design/bfr_in_reg.sv
// ----------------------------------------------------------------------------
// bfr_in_reg
// Input register: captures one request beat and holds it until the engine
// consumes it.
// ----------------------------------------------------------------------------
module bfr_in_reg import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bfr_req_type req_data,
   input  logic        advance,
   output logic        item_valid,
   output bfr_req_type item_data
);

   logic        valid_ff;
   logic        valid_in;
   bfr_req_type data_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// File: design/bfr_engine.sv
// ----------------------------------------------------------------------------
// bfr_engine
// Deframer state and per-beat update: header hunt, length, body, checksum,
// field latches and idle timeout.
// ----------------------------------------------------------------------------
module bfr_engine import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bfr_cfg_type cfg,
   input  logic        advance,
   input  bfr_req_type item_data,
   output bfr_rsp_type result
);

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_LEN_LO = 2'd1;
   localparam logic [1:0] PH_LEN_HI = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_CAPACITY - 1);

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [15:0]      target_ff, target_in;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      idle_ff, idle_in;
   logic             armed_ff, armed_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       dir_ff, dir_in;
   logic [7:0]       cmd_ff, cmd_in;

   logic [7:0]       b;
   logic [POS_W-1:0] at;
   logic [POS_W-1:0] at_next;
   logic [15:0]      idle_inc;
   logic             type_match;

   always_comb begin
      b          = item_data.rx_byte;
      phase_in   = phase_ff;
      position_in = position_ff;
      target_in  = target_ff;
      sum_in     = sum_ff;
      idle_in    = idle_ff;
      armed_in   = armed_ff;
      id_in      = id_ff;
      type_in    = type_ff;
      dir_in     = dir_ff;
      cmd_in     = cmd_ff;
      at         = position_ff;
      at_next    = (position_ff == POS_LAST) ? '0 : position_ff + 1'b1;
      idle_inc   = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      type_match = 1'b0;

      result               = '0;
      result.event_res     = EV_NONE;

      if (item_data.action == ACT_TICK) begin
         if (armed_ff) begin
            idle_in = idle_inc;
            if (idle_inc >= cfg.timeout_ticks) begin
               phase_in = PH_HUNT;
               armed_in = 1'b0;
               idle_in  = '0;
               result.event_res = EV_TIMEOUT;
            end
         end
      end else begin
         result.data_byte = b;
         case (phase_ff)
            PH_HUNT: begin
               if (b == HEADER_BYTE) begin
                  // new frame starts at offset zero
                  phase_in    = PH_LEN_LO;
                  armed_in    = 1'b1;
                  idle_in     = '0;
                  sum_in      = '0;
                  at          = '0;
                  position_in = (POS_LAST == '0) ? '0 : POS_W'(1);
                  result.event_res = EV_HEADER;
               end
            end
            PH_LEN_LO: begin
               target_in   = {8'h00, b};
               position_in = at_next;
               phase_in    = PH_LEN_HI;
               result.event_res = EV_LENGTH;
            end
            PH_LEN_HI: begin
               target_in   = {b, target_ff[7:0]} + 16'd4;
               position_in = at_next;
               phase_in    = PH_BODY;
               result.event_res = EV_LENGTH;
            end
            default: begin
               armed_in    = 1'b1;
               idle_in     = '0;
               position_in = at_next;
               if (at == POS_W'(3)) id_in   = b;
               if (at == POS_W'(4)) type_in = b;
               if (at == POS_W'(5)) dir_in  = b;
               if (at == POS_W'(6)) cmd_in  = b;
               if (16'(at_next) >= target_ff) begin
                  phase_in = PH_HUNT;
                  armed_in = 1'b0;
                  if (sum_ff == b) begin
                     result.event_res = EV_GOOD;
                     if (dir_in == 8'd0) begin
                        type_match = (type_in == cfg.my_device_type);
                     end else if (dir_in == 8'd1) begin
                        type_match = (type_in == cfg.my_device_type) ||
                                     (type_in == ANY_TYPE);
                     end
                  end else begin
                     result.event_res = EV_CSUM;
                  end
               end else begin
                  sum_in = sum_ff + b;
                  result.event_res = EV_BODY;
               end
            end
         endcase
         if (result.event_res != EV_NONE) begin
            result.byte_position = 10'(at);
         end
      end

      result.frame_size    = target_in;
      result.device_id     = id_in;
      result.device_type   = type_in;
      result.direction     = dir_in;
      result.command       = cmd_in;
      result.for_this_node = type_match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         position_ff <= '0;
         target_ff   <= '0;
         sum_ff      <= '0;
         idle_ff     <= '0;
         armed_ff    <= 1'b0;
         id_ff       <= '0;
         type_ff     <= '0;
         dir_ff      <= '0;
         cmd_ff      <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         target_ff   <= target_in;
         sum_ff      <= sum_in;
         idle_ff     <= idle_in;
         armed_ff    <= armed_in;
         id_ff       <= id_in;
         type_ff     <= type_in;
         dir_ff      <= dir_in;
         cmd_ff      <= cmd_in;
      end
   end

endmodule

// File: design/bfr_out_reg.sv
// ----------------------------------------------------------------------------
// bfr_out_reg
// Result register: holds one response beat until the consumer takes it.
// ----------------------------------------------------------------------------
module bfr_out_reg import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  bfr_rsp_type result,
   output logic        advance,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bfr_rsp_type rsp_data
);

   logic        valid_ff;
   logic        valid_in;
   bfr_rsp_type data_ff;

   // the engine moves whenever this slot is empty or being drained
   assign advance  = item_valid && (!valid_ff || rsp_ready);
   assign valid_in = advance ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: design/bus_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// bus_frame_receiver_core
// Serial frame deframer: header hunt, 16-bit length, additive checksum,
// field latches and idle timeout, one response beat per request beat.
//
//   channel   ports                          direction
//   req       req_valid/req_ready/req_data   in   (byte or tick)
//   rsp       rsp_valid/rsp_ready/rsp_data   out  (one event per request)
//   csr       csr_we/csr_index/csr_wdata     in   (write only)
//
// A request beat is captured in the input register, then the engine
// updates its state and loads the result register; one beat per cycle
// sustained while rsp is ready. Backpressure on rsp holds both registers;
// the input register still takes a beat while the result waits, if empty.
// Synchronous reset returns to header hunt with timeout_ticks = 700.
// ----------------------------------------------------------------------------
module bus_frame_receiver_core import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bfr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bfr_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   bfr_cfg_type cfg_ff;
   logic        advance;
   logic        item_valid;
   bfr_req_type item_data;
   bfr_rsp_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
         cfg_ff.my_device_type <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr_wdata;
            CSR_MY_DEVICE_TYPE: cfg_ff.my_device_type <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   bfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   bfr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .advance   (advance),
      .item_data (item_data),
      .result    (result)
   );

   bfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: verif/bfr_frame_checker.sv
// ----------------------------------------------------------------------------
// bfr_frame_checker
// Watches the req, rsp and csr ports of the frame receiver. Every req beat
// runs through a cycle-free deframer model that yields the expected rsp
// beat, and each rsp beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module bfr_frame_checker import bfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  bfr_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  bfr_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          errors,
   output int          pending
);

   typedef enum logic [1:0] {HUNT, LEN_LO, LEN_HI, BODY} rx_phase_type;

   localparam logic [7:0] DIR_DOWN = 8'h00;
   localparam logic [7:0] DIR_UP   = 8'h01;

   logic [15:0]      timeout_q;
   logic [7:0]       my_type_q;

   rx_phase_type     phase_q;
   logic [POS_W-1:0] pos_q;
   logic [15:0]      size_q;
   logic [7:0]       sum_q;
   logic [15:0]      idle_q;
   logic             armed_q;
   logic [7:0]       id_q;
   logic [7:0]       type_q;
   logic [7:0]       dir_q;
   logic [7:0]       cmd_q;

   bfr_rsp_type      predicted_events [$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   // store a frame byte; frame offsets 3..6 in the body latch the header fields
   function automatic logic [POS_W-1:0] take_byte(logic [7:0] b);
      logic [POS_W-1:0] at;
      at = pos_q;
      if (phase_q == BODY) begin
         case (at)
            3: id_q   = b;
            4: type_q = b;
            5: dir_q  = b;
            6: cmd_q  = b;
            default: ;
         endcase
      end
      pos_q = (int'(at) + 1 >= FRAME_CAPACITY) ? '0 : at + 1'b1;
      return at;
   endfunction

   function automatic bfr_rsp_type deframe_step(bfr_req_type beat);
      bfr_rsp_type r;
      logic [7:0]  b;
      r = '0;
      b = beat.rx_byte;
      if (beat.action == ACT_TICK) begin
         if (armed_q) begin
            if (idle_q != 16'hFFFF) idle_q = idle_q + 1'b1;
            if (idle_q >= timeout_q) begin
               phase_q     = HUNT;
               armed_q     = 1'b0;
               idle_q      = '0;
               r.event_res = EV_TIMEOUT;
            end
         end
      end else begin
         r.data_byte = b;
         case (phase_q)
            HUNT: if (b == HEADER_BYTE) begin
               phase_q         = LEN_LO;
               armed_q         = 1'b1;
               idle_q          = '0;
               sum_q           = '0;
               pos_q           = '0;
               r.byte_position = take_byte(b);
               r.event_res     = EV_HEADER;
            end
            LEN_LO: begin
               size_q          = {8'h00, b};
               r.byte_position = take_byte(b);
               phase_q         = LEN_HI;
               r.event_res     = EV_LENGTH;
            end
            LEN_HI: begin
               size_q          = {b, size_q[7:0]} + 16'd4;
               r.byte_position = take_byte(b);
               phase_q         = BODY;
               r.event_res     = EV_LENGTH;
            end
            default: begin
               armed_q         = 1'b1;
               idle_q          = '0;
               r.byte_position = take_byte(b);
               if (pos_q >= size_q) begin
                  // last byte of the frame carries the checksum
                  phase_q = HUNT;
                  armed_q = 1'b0;
                  idle_q  = '0;
                  if (sum_q == b) begin
                     r.event_res = EV_GOOD;
                     if (dir_q == DIR_DOWN)
                        r.for_this_node = (type_q == my_type_q);
                     else if (dir_q == DIR_UP)
                        r.for_this_node = (type_q == my_type_q) || (type_q == ANY_TYPE);
                  end else begin
                     r.event_res = EV_CSUM;
                  end
               end else begin
                  sum_q       = sum_q + b;
                  r.event_res = EV_BODY;
               end
            end
         endcase
      end
      r.frame_size  = size_q;
      r.device_id   = id_q;
      r.device_type = type_q;
      r.direction   = dir_q;
      r.command     = cmd_q;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      bfr_rsp_type want;
      if (reset) begin
         timeout_q = TIMEOUT_RESET;
         my_type_q = '0;
         phase_q   = HUNT;
         pos_q     = '0;
         size_q    = '0;
         sum_q     = '0;
         idle_q    = '0;
         armed_q   = 1'b0;
         id_q      = '0;
         type_q    = '0;
         dir_q     = '0;
         cmd_q     = '0;
         predicted_events.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_TIMEOUT_TICKS) timeout_q = csr_wdata;
            else my_type_q = csr_wdata[7:0];
         end
         if (req_valid && req_ready) predicted_events.push_back(deframe_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_events.size() == 0) begin
               $error("rsp beat with no request outstanding");
               errors++;
            end else begin
               want = predicted_events.pop_front();
               check_field("event_res", 16'(want.event_res),
                           16'(rsp_data.event_res));
               check_field("data_byte", 16'(want.data_byte),
                           16'(rsp_data.data_byte));
               check_field("byte_position", 16'(want.byte_position),
                           16'(rsp_data.byte_position));
               check_field("frame_size", want.frame_size, rsp_data.frame_size);
               check_field("device_id", 16'(want.device_id),
                           16'(rsp_data.device_id));
               check_field("device_type", 16'(want.device_type),
                           16'(rsp_data.device_type));
               check_field("direction", 16'(want.direction),
                           16'(rsp_data.direction));
               check_field("command", 16'(want.command),
                           16'(rsp_data.command));
               check_field("for_this_node", 16'(want.for_this_node),
                           16'(rsp_data.for_this_node));
            end
         end
      end
      pending <= predicted_events.size();
   end

endmodule

// File: verif/bus_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// bus_frame_receiver_core_tb
// Drives byte and tick beats into the frame receiver: a short directed
// sequence, then well-formed frames with random content, bad checksums,
// wrapped sizes, abandoned and oversized frames, under several csr settings.
// Both channels idle at random; the checker module judges every rsp beat.
// ----------------------------------------------------------------------------
module bus_frame_receiver_core_tb;
   import bfr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   bfr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   bfr_rsp_type rsp_data;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_TIMEOUT_TICKS;
   logic [15:0] csr_wdata = '0;

   int          mismatches;
   int          outstanding;
   int          cycles      = 0;
   int          items_sent  = 0;
   int          req_calm    = 0;
   int          rsp_calm    = 0;
   logic [15:0] cur_timeout = TIMEOUT_RESET;
   logic [7:0]  cur_type    = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bus_frame_receiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bfr_frame_checker u_frame_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (mismatches),
      .pending   (outstanding)
   );

   // idle cycles before the next beat; runs of zero now and then
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 48);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic send_item(logic act, logic [7:0] b);
      bfr_req_type beat;
      int          gap;
      beat.action  = act;
      beat.rx_byte = b;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(logic [15:0] ticks, logic [7:0] node_type);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_index <= CSR_MY_DEVICE_TYPE;
      csr_wdata <= {8'h00, node_type};
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_timeout = ticks;
      cur_type    = node_type;
   endtask

   // cut >= 0 abandons the frame after that many body bytes and lets it time out
   task automatic send_frame(logic [15:0] len, bit corrupt, int cut);
      logic [15:0] size;
      logic [7:0]  sum;
      logic [7:0]  b;
      int          nbody;
      int          r;
      size  = len + 16'd4;
      nbody = (size >= 16'd4) ? int'(size) - 3 : 1;
      sum   = '0;
      send_item(ACT_BYTE, HEADER_BYTE);
      if ($urandom_range(0, 9) == 0) send_item(ACT_TICK, 8'($urandom));
      send_item(ACT_BYTE, len[7:0]);
      send_item(ACT_BYTE, len[15:8]);
      for (int k = 0; k < nbody; k++) begin
         if (k == cut) begin
            repeat (int'(cur_timeout) + 1) send_item(ACT_TICK, 8'($urandom));
            return;
         end
         if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 2)) send_item(ACT_TICK, 8'($urandom));
         r = $urandom_range(0, 9);
         if (k == nbody - 1) begin
            b = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
         end else if (k == 1) begin
            b = (r < 6) ? cur_type : (r < 8) ? ANY_TYPE : 8'($urandom);
         end else if (k == 2) begin
            b = (r < 8) ? 8'($urandom_range(0, 1)) : 8'($urandom);
         end else begin
            b = 8'($urandom);
         end
         sum = sum + b;
         send_item(ACT_BYTE, b);
      end
   endtask

   task automatic random_traffic(int count);
      logic [15:0] len;
      int          start;
      int          r;
      int          cut;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
         r = $urandom_range(0, 99);
         if (r < 70) len = 16'($urandom_range(0, 12));
         else if (r < 80) len = 16'hFFFC + 16'($urandom_range(0, 3));
         else len = 16'($urandom_range(13, 40));
         cut = -1;
         if (cur_timeout <= 16'd64 && $urandom_range(0, 7) == 0)
            cut = $urandom_range(0, 3);
         send_frame(len, $urandom_range(0, 4) == 0, cut);
         if ($urandom_range(0, 63) == 0) drain();
      end
   endtask

   // rsp side: random stall before each beat
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_gap(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      static logic [8:0] script [27] = '{
         {ACT_TICK, 8'h3C}, {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'hFF},
         // good frame, size 7, down to type 0
         {ACT_BYTE, HEADER_BYTE}, {ACT_BYTE, 8'h03}, {ACT_BYTE, 8'h00},
         {ACT_BYTE, 8'hAA}, {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'hAA},
         // size wraps to 0: lone checksum byte
         {ACT_BYTE, HEADER_BYTE}, {ACT_BYTE, 8'hFC}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'h00},
         // size wraps to 3, checksum wrong
         {ACT_BYTE, HEADER_BYTE}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'h55},
         // up frame to any type, tick inside
         {ACT_BYTE, HEADER_BYTE}, {ACT_BYTE, 8'h04}, {ACT_BYTE, 8'h00}, {ACT_TICK, 8'hA5},
         {ACT_BYTE, 8'h11}, {ACT_BYTE, 8'hFF}, {ACT_BYTE, 8'h01}, {ACT_BYTE, 8'hC3},
         {ACT_BYTE, 8'hD4}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_item(script[i][8], script[i][7:0]);
      random_traffic(100);

      drain();
      write_config(16'd1, 8'hFF);
      random_traffic(110);

      drain();
      write_config(16'd0, 8'h00);
      random_traffic(80);

      // longest timeout: a header followed by a run of ticks stays pending
      drain();
      write_config(16'd65535, 8'h5A);
      random_traffic(90);
      send_item(ACT_BYTE, HEADER_BYTE);
      repeat (40) send_item(ACT_TICK, 8'($urandom));

      // oversized frame: position wraps, only the timeout can end it
      drain();
      write_config(16'd3, 8'($urandom));
      repeat (4) send_item(ACT_TICK, 8'($urandom));
      send_item(ACT_BYTE, HEADER_BYTE);
      send_item(ACT_BYTE, 8'h1A);
      send_item(ACT_BYTE, 8'h04);
      repeat (1030) send_item(ACT_BYTE, 8'($urandom));
      repeat (4) send_item(ACT_TICK, 8'($urandom));
      random_traffic(60);

      drain();
      write_config(16'($urandom_range(2, 40)), 8'($urandom));
      random_traffic(70);

      drain();
      write_config(16'd700, 8'hFF);
      random_traffic(70);

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
design/bfr_pkg.sv
design/bfr_in_reg.sv
design/bfr_engine.sv
design/bfr_out_reg.sv
design/bus_frame_receiver_core.sv
verif/bfr_frame_checker.sv
verif/bus_frame_receiver_core_tb.sv
